FILE: rtl/wma_pkg.sv
// ----------------------------------------------------------------------------
// wma_pkg: shared widths for the window mean moving average
// Field widths of the sample and result transfers and the step count of the
// serial divider.
// ----------------------------------------------------------------------------
package wma_pkg;

  // Raw sensor sample width and the 16.8 fixed point mean width.
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 8;
  localparam int MEAN_W   = SAMPLE_W + FRAC_W;

  // Counter width for the quotient bits produced one per cycle.
  localparam int STEP_W   = $clog2(MEAN_W);

endpackage

FILE: rtl/wma_in_if.sv
// ----------------------------------------------------------------------------
// wma_in_if: sample channel
// Valid/ready channel carrying one infrared and red sample pair.
// ----------------------------------------------------------------------------
interface wma_in_if;
  import wma_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] ir_sample;
  logic [SAMPLE_W-1:0] red_sample;
  logic                window_end;

  modport source (output valid, output ir_sample, output red_sample, output window_end,
                  input ready);
  modport sink   (input valid, input ir_sample, input red_sample, input window_end,
                  output ready);
endinterface

FILE: rtl/wma_out_if.sv
// ----------------------------------------------------------------------------
// wma_out_if: average channel
// Valid/ready channel carrying one pair of moving averages per window.
// ----------------------------------------------------------------------------
interface wma_out_if;
  import wma_pkg::*;

  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] ir_average;
  logic [MEAN_W-1:0] red_average;
  logic              window_overflow;

  modport source (output valid, output ir_average, output red_average,
                  output window_overflow, input ready);
  modport sink   (input valid, input ir_average, input red_average,
                  input window_overflow, output ready);
endinterface

FILE: rtl/wma_ram.sv
// ----------------------------------------------------------------------------
// wma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/wma_div.sv
// ----------------------------------------------------------------------------
// wma_div: bit-serial restoring divider
// Produces a 24-bit quotient, one bit per cycle. The caller supplies the
// upper part of the dividend as the starting remainder, which must already
// be below the divisor, and the lower 24 dividend bits.
// ----------------------------------------------------------------------------
module wma_div #(
  parameter int DW = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DW-1:0]             rem_init,
  input  logic [wma_pkg::MEAN_W-1:0] low,
  input  logic [DW-1:0]             divisor,
  output logic [wma_pkg::MEAN_W-1:0] quotient,
  output logic                      done
);
  import wma_pkg::*;

  logic [DW-1:0]     rem;
  logic [DW-1:0]     rem_next;
  logic [DW-1:0]     dvsr;
  logic [MEAN_W-1:0] shreg;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DW:0]       trial;
  logic [DW+1:0]     diff;
  logic              qbit;

  // The dividend bits leave the top of the shift register as quotient bits
  // enter at the bottom.
  assign trial    = {rem, shreg[MEAN_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvsr};
  assign qbit     = ~diff[DW+1];
  assign rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      shreg <= low;
      dvsr  <= divisor;
      steps <= STEP_W'(MEAN_W - 1);
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[MEAN_W-2:0], qbit};
      steps <= steps - 1'b1;
    end
  end
endmodule

FILE: rtl/window_mean_moving_average.sv
// ----------------------------------------------------------------------------
// window_mean_moving_average: moving average of windowed sensor means
// Sums paired infrared and red samples over a window, takes each window mean
// in unsigned 16.8 fixed point and reports the mean of the last
// HISTORY_DEPTH window means.
//
// Usage. Samples arrive on the samples channel; a transfer whose window_end
// is high closes the window. Each closed window yields exactly one transfer
// on the averages channel; other samples yield none. Samples are accepted one
// per cycle while no window is being closed. Closing a window holds the
// samples channel off for two passes of a bit-serial divider (the window
// sum by the sample count, then the history sum by the depth) and for
// loading the divider twice, seeing each pass finish, updating the history
// and handing over to the output register once that register is free.
// Once a window has been handed to the output register the block takes
// samples again at once, even while that result still waits; if the receiver
// stalls for so long that the next window closes too, the second result is
// held back until the first transfer completes. Samples beyond
// MAX_WINDOW_SAMPLES in one window are dropped and reported by
// window_overflow. Reset clears the sums, counters and the output; the
// history reads as zero until each slot has been written once.
// ----------------------------------------------------------------------------
module window_mean_moving_average #(
  parameter int HISTORY_DEPTH      = 8,
  parameter int MAX_WINDOW_SAMPLES = 256
) (
  input logic      clk,
  input logic      rst,
  wma_in_if.sink   samples,
  wma_out_if.source averages
);
  import wma_pkg::*;

  // Sample count, window sum, history address and running sum widths.
  localparam int CW      = $clog2(MAX_WINDOW_SAMPLES + 1);
  localparam int SW      = SAMPLE_W + CW;
  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int RW      = MEAN_W + AW;
  localparam int DEPTH_W = $clog2(HISTORY_DEPTH + 1);
  localparam int DW      = (CW > DEPTH_W) ? CW : DEPTH_W;

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_LOAD       = 7'b0000010,
    S_MEAN       = 7'b0000100,
    S_UPDATE     = 7'b0001000,
    S_SCALE_LOAD = 7'b0010000,
    S_SCALE      = 7'b0100000,
    S_EMIT       = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Window accumulation.
  logic [SW-1:0] ir_window_sum;
  logic [SW-1:0] red_window_sum;
  logic [CW-1:0] window_count;
  logic          overflow_seen;
  logic          window_ovf;

  // History and running sums.
  logic [AW-1:0]       slot_pointer;
  logic                wrapped;
  logic [RW-1:0]       ir_running_sum;
  logic [RW-1:0]       red_running_sum;
  logic [2*MEAN_W-1:0] hist_rdata;
  logic [MEAN_W-1:0]   ir_old;
  logic [MEAN_W-1:0]   red_old;

  // Divider connections.
  logic              div_start;
  logic              scale_sel;
  logic [DW-1:0]     divisor;
  logic [DW-1:0]     ir_rem_init;
  logic [DW-1:0]     red_rem_init;
  logic [MEAN_W-1:0] ir_low;
  logic [MEAN_W-1:0] red_low;
  logic [MEAN_W-1:0] ir_quot;
  logic [MEAN_W-1:0] red_quot;
  logic              ir_done;
  logic              red_done;

  // Output register.
  logic              out_valid;
  logic [MEAN_W-1:0] ir_average;
  logic [MEAN_W-1:0] red_average;
  logic              window_overflow;

  logic accept;
  logic out_free;

  assign samples.ready            = (state == S_IDLE);
  assign accept                   = samples.valid && samples.ready;
  assign out_free                 = !out_valid || averages.ready;

  assign averages.valid           = out_valid;
  assign averages.ir_average      = ir_average;
  assign averages.red_average     = red_average;
  assign averages.window_overflow = window_overflow;

  // The divider runs twice per window. For the mean, the dividend is the
  // window sum times 256: its bits above the quotient are sum >> 16, which
  // is always below the sample count. For the average, the dividend is the
  // running sum, whose bits above the quotient are below the depth.
  assign div_start    = (state == S_LOAD) || (state == S_SCALE_LOAD);
  assign scale_sel    = (state == S_SCALE_LOAD);
  assign divisor      = scale_sel ? DW'(HISTORY_DEPTH) : DW'(window_count);
  assign ir_rem_init  = scale_sel ? DW'(ir_running_sum[RW-1:MEAN_W])
                                  : DW'(ir_window_sum[SW-1:SAMPLE_W]);
  assign red_rem_init = scale_sel ? DW'(red_running_sum[RW-1:MEAN_W])
                                  : DW'(red_window_sum[SW-1:SAMPLE_W]);
  assign ir_low       = scale_sel ? ir_running_sum[MEAN_W-1:0]
                                  : {ir_window_sum[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
  assign red_low      = scale_sel ? red_running_sum[MEAN_W-1:0]
                                  : {red_window_sum[SAMPLE_W-1:0], {FRAC_W{1'b0}}};

  wma_div #(.DW(DW)) u_ir_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (ir_rem_init),
    .low      (ir_low),
    .divisor  (divisor),
    .quotient (ir_quot),
    .done     (ir_done)
  );

  wma_div #(.DW(DW)) u_red_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (red_rem_init),
    .low      (red_low),
    .divisor  (divisor),
    .quotient (red_quot),
    .done     (red_done)
  );

  // Both channels' means share one history word. The read address follows
  // the slot pointer, so the old entry is ready long before the update.
  wma_ram #(.WIDTH(2 * MEAN_W), .DEPTH(HISTORY_DEPTH)) u_history (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (slot_pointer),
    .wdata ({ir_quot, red_quot}),
    .raddr (slot_pointer),
    .rdata (hist_rdata)
  );

  // Until the pointer has wrapped once, the slot about to be replaced has
  // never been written and counts as zero.
  assign ir_old  = wrapped ? hist_rdata[2*MEAN_W-1:MEAN_W] : '0;
  assign red_old = wrapped ? hist_rdata[MEAN_W-1:0] : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (accept && samples.window_end) state_next = S_LOAD;
      S_LOAD:       state_next = S_MEAN;
      S_MEAN:       if (ir_done && red_done) state_next = S_UPDATE;
      S_UPDATE:     state_next = S_SCALE_LOAD;
      S_SCALE_LOAD: state_next = S_SCALE;
      S_SCALE:      if (ir_done && red_done) state_next = S_EMIT;
      S_EMIT:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ir_window_sum   <= '0;
      red_window_sum  <= '0;
      window_count    <= '0;
      overflow_seen   <= 1'b0;
      window_ovf      <= 1'b0;
      slot_pointer    <= '0;
      wrapped         <= 1'b0;
      ir_running_sum  <= '0;
      red_running_sum <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      // Samples past the window limit are dropped, the closing one included.
      if (accept) begin
        if (window_count < CW'(MAX_WINDOW_SAMPLES)) begin
          ir_window_sum  <= ir_window_sum + SW'(samples.ir_sample);
          red_window_sum <= red_window_sum + SW'(samples.red_sample);
          window_count   <= window_count + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      // The divider has taken the sums, so the next window can start clean.
      if (state == S_LOAD) begin
        window_ovf     <= overflow_seen;
        ir_window_sum  <= '0;
        red_window_sum <= '0;
        window_count   <= '0;
        overflow_seen  <= 1'b0;
      end

      if (state == S_UPDATE) begin
        ir_running_sum  <= ir_running_sum - RW'(ir_old) + RW'(ir_quot);
        red_running_sum <= red_running_sum - RW'(red_old) + RW'(red_quot);
        if (slot_pointer == AW'(HISTORY_DEPTH - 1)) begin
          slot_pointer <= '0;
          wrapped      <= 1'b1;
        end else begin
          slot_pointer <= slot_pointer + 1'b1;
        end
      end

      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (averages.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      ir_average      <= ir_quot;
      red_average     <= red_quot;
      window_overflow <= window_ovf;
    end
  end
endmodule
